>>> rtl/p8cpu_pkg.sv
// shared types and constants for the 8-bit cpu step block
`timescale 1ns / 1ps
package p8cpu_pkg;

	localparam logic [2:0] KIND_WRITE = 3'd0;
	localparam logic [2:0] KIND_READ  = 3'd1;
	localparam logic [2:0] KIND_EXEC  = 3'd2;
	localparam logic [2:0] KIND_IRQ   = 3'd3;
	localparam logic [2:0] KIND_NMI   = 3'd4;

	localparam int unsigned FL_C = 0;
	localparam int unsigned FL_Z = 1;
	localparam int unsigned FL_I = 2;
	localparam int unsigned FL_B = 4;
	localparam int unsigned FL_V = 5;
	localparam int unsigned FL_N = 6;

	localparam logic [15:0] VEC_IRQ = 16'hfffe;
	localparam logic [15:0] VEC_NMI = 16'hfffa;
	localparam logic [7:0]  STACK_PAGE = 8'h01;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MEMRD,
		ST_OPC,
		ST_OPR,
		ST_PUSH_LO,
		ST_PUSH_HI,
		ST_PUSH_FL,
		ST_VEC_LO,
		ST_VEC_HI,
		ST_JSR_HI,
		ST_POP_FL,
		ST_POP_HI,
		ST_POP_LO,
		ST_PTR_LO,
		ST_PTR_HI,
		ST_DATA,
		ST_DONE
	} state_t;

endpackage

>>> rtl/partial_8bit_cpu_step.sv
// top level of the 8-bit cpu step block: sequencer around one byte-wide memory
// throughput: one item at a time, set by the single memory port (one access a cycle)
// the result sits in an output register; the next item is taken the cycle after it is transferred
// reset clears architectural registers, flags, nmi latch and handshake state; memory is not cleared
`timescale 1ns / 1ps
module partial_8bit_cpu_step
	import p8cpu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [15:0] address,
	input  logic [7:0]  data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] pc,
	output logic [7:0]  acc,
	output logic [7:0]  x_index,
	output logic [7:0]  y_index,
	output logic [7:0]  stack_pointer,
	output logic [6:0]  flags,
	output logic [7:0]  read_data,
	output logic        ignored
);

	// single-port memory, read data registered and valid the cycle after its address
	logic [7:0]  mem [0:65535];
	logic [15:0] mem_addr;
	logic        mem_we;
	logic [7:0]  mem_wdata;
	logic [7:0]  rd;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wdata;
		rd <= mem[mem_addr];
	end

	// architectural state
	logic [15:0] pc_q;
	logic [7:0]  a_q, x_q, y_q, sp_q;
	logic [6:0]  fl_q;
	logic        nmi_q;
	state_t      state_q, state_d;

	// working registers of the current item
	logic [2:0]  kind_q;
	logic [7:0]  op_q;
	logic [7:0]  tmp_q;   // operand, pointer, popped byte or vector low byte
	logic [15:0] ptmp_q;  // value being pushed
	logic [15:0] ea_q;
	logic        out_valid_q;
	logic [7:0]  rdata_q;
	logic        ign_q;

	// next values
	logic [15:0] pc_d, ptmp_d, ea_d;
	logic [7:0]  a_d, x_d, y_d, sp_d, tmp_d, rdata_d;
	logic [6:0]  fl_d;
	logic        nmi_d, ign_d, fin;

	wire [3:0] op_lo = op_q[3:0];
	wire [3:0] op_hi = op_q[7:4];

	function automatic logic [6:0] nz(input logic [6:0] f, input logic [7:0] v);
		logic [6:0] r;
		r = f;
		r[FL_Z] = (v == 8'd0);
		r[FL_N] = v[7];
		return r;
	endfunction

	assign in_ready = (state_q == ST_IDLE) && !out_valid_q;

	// branch condition from the flag selected by the opcode
	logic br_flag;
	always_comb begin
		case (op_hi[3:2])
			2'd0: br_flag = fl_q[FL_N];
			2'd1: br_flag = fl_q[FL_V];
			2'd2: br_flag = fl_q[FL_C];
			default: br_flag = fl_q[FL_Z];
		endcase
	end

	logic [8:0] alu_t;
	always_comb begin
		state_d   = state_q;
		mem_addr  = pc_q;
		mem_we    = 1'b0;
		mem_wdata = a_q;
		pc_d = pc_q; a_d = a_q; x_d = x_q; y_d = y_q; sp_d = sp_q; fl_d = fl_q;
		nmi_d = nmi_q; tmp_d = tmp_q; ptmp_d = ptmp_q; ea_d = ea_q;
		rdata_d = rdata_q; ign_d = ign_q; fin = 1'b0;
		alu_t = 9'd0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					rdata_d = 8'd0;
					ign_d = 1'b0;
					case (kind)
						KIND_WRITE: begin
							mem_addr = address;
							mem_we = 1'b1;
							mem_wdata = data;
							fin = 1'b1;
						end
						KIND_READ: begin
							mem_addr = address;
							state_d = ST_MEMRD;
						end
						KIND_EXEC: begin
							// opcode fetch from the program counter
							pc_d = pc_q + 16'd1;
							state_d = ST_OPC;
						end
						KIND_IRQ: begin
							if (fl_q[FL_I]) begin
								ign_d = 1'b1;
								fin = 1'b1;
							end else begin
								ptmp_d = pc_q;
								state_d = ST_PUSH_LO;
							end
						end
						KIND_NMI: begin
							if (nmi_q) begin
								ign_d = 1'b1;
								fin = 1'b1;
							end else begin
								ptmp_d = pc_q;
								state_d = ST_PUSH_LO;
							end
						end
						default: fin = 1'b1;
					endcase
				end
			end
			ST_MEMRD: begin
				rdata_d = rd;
				fin = 1'b1;
			end
			ST_OPC: begin
				// rd holds the opcode; fetch the next byte in case it is needed
				mem_addr = pc_q;
				if (rd[3:0] == 4'h0 && rd[7:4] == 4'h0) begin
					ptmp_d = pc_q + 16'd1;
					fl_d[FL_B] = 1'b1;
					state_d = ST_PUSH_LO;
				end else if (rd[3:0] == 4'h0 && rd[7:4] == 4'h4) begin
					sp_d = sp_q + 8'd1;
					mem_addr = {STACK_PAGE, sp_q + 8'd1};
					state_d = ST_POP_FL;
				end else if (rd[3:0] == 4'h0 && rd[7:4] == 4'h6) begin
					sp_d = sp_q + 8'd1;
					mem_addr = {STACK_PAGE, sp_q + 8'd1};
					state_d = ST_POP_HI;
				end else if ((rd[3:0] == 4'h0 && rd[7:4] == 4'h8) || rd[3:0] > 4'h2) begin
					fin = 1'b1;
				end else if (rd[3:0] == 4'h0 && rd[7:4] == 4'h2) begin
					// jsr: pushes the address of its last operand byte
					ptmp_d = pc_q + 16'd1;
					ea_d = pc_q;
					state_d = ST_PUSH_LO;
				end else if ((rd[3:0] == 4'h0 && rd[4] == 1'b0) &&
						!(rd[7:4] == 4'ha || rd[7:4] == 4'hc || rd[7:4] == 4'he)) begin
					fin = 1'b1;
				end else begin
					pc_d = pc_q + 16'd1;
					state_d = ST_OPR;
				end
			end
			ST_OPR: begin
				tmp_d = rd;
				if (op_lo == 4'h2) begin
					x_d = rd;
					fl_d = nz(fl_q, rd);
					fin = 1'b1;
				end else if (op_lo == 4'h0 && op_hi[0]) begin
					if (br_flag == op_hi[1])
						pc_d = pc_q + {{8{rd[7]}}, rd};
					fin = 1'b1;
				end else if (op_lo == 4'h0 && op_hi == 4'ha) begin
					y_d = rd;
					fl_d = nz(fl_q, rd);
					fin = 1'b1;
				end else if (op_lo == 4'h0) begin
					alu_t = {1'b0, (op_hi == 4'hc) ? y_q : x_q} - {1'b0, rd};
					fl_d = nz(fl_q, alu_t[7:0]);
					fl_d[FL_C] = alu_t[8];
					fin = 1'b1;
				end else begin
					mem_addr = {8'h00, op_hi[0] ? rd : rd + x_q};
					tmp_d = op_hi[0] ? rd : rd + x_q;
					state_d = ST_PTR_LO;
				end
			end
			ST_PTR_LO: begin
				mem_addr = {8'h00, tmp_q + 8'd1};
				ea_d[7:0] = op_hi[0] ? rd + y_q : rd;
				state_d = ST_PTR_HI;
			end
			ST_PTR_HI: begin
				mem_addr = {rd, ea_q[7:0]};
				ea_d[15:8] = rd;
				if (op_hi[3:1] == 3'd4) begin
					mem_we = 1'b1;
					mem_wdata = a_q;
					fin = 1'b1;
				end else begin
					state_d = ST_DATA;
				end
			end
			ST_DATA: begin
				case (op_hi[3:1])
					3'd0: begin a_d = a_q | rd; fl_d = nz(fl_q, a_q | rd); end
					3'd1: begin a_d = a_q & rd; fl_d = nz(fl_q, a_q & rd); end
					3'd2: begin a_d = a_q ^ rd; fl_d = nz(fl_q, a_q ^ rd); end
					3'd3: begin
						alu_t = {1'b0, a_q} + {1'b0, rd} + {8'd0, fl_q[FL_C]};
						a_d = alu_t[7:0];
						fl_d = nz(fl_q, alu_t[7:0]);
						fl_d[FL_C] = alu_t[8];
					end
					3'd5: begin a_d = rd; fl_d = nz(fl_q, rd); end
					3'd6: begin
						alu_t = {1'b0, a_q} - {1'b0, rd};
						fl_d = nz(fl_q, alu_t[7:0]);
						fl_d[FL_C] = alu_t[8];
					end
					default: begin
						alu_t = {1'b0, a_q} - {1'b0, rd} - {8'd0, fl_q[FL_C]};
						a_d = alu_t[7:0];
						fl_d = nz(fl_q, alu_t[7:0]);
						fl_d[FL_C] = alu_t[8];
					end
				endcase
				fin = 1'b1;
			end
			ST_PUSH_LO: begin
				mem_addr = {STACK_PAGE, sp_q};
				mem_we = 1'b1;
				mem_wdata = ptmp_q[7:0];
				sp_d = sp_q - 8'd1;
				state_d = ST_PUSH_HI;
			end
			ST_PUSH_HI: begin
				mem_addr = {STACK_PAGE, sp_q};
				mem_we = 1'b1;
				mem_wdata = ptmp_q[15:8];
				sp_d = sp_q - 8'd1;
				if (kind_q == KIND_EXEC && op_hi == 4'h2) begin
					mem_we = 1'b1;
					state_d = ST_JSR_HI;
				end else begin
					state_d = ST_PUSH_FL;
				end
			end
			ST_JSR_HI: begin
				// read jump target or vector, low then high; its address is held in ea_q
				mem_addr = ea_q;
				ea_d = ea_q + 16'd1;
				state_d = ST_VEC_LO;
			end
			ST_PUSH_FL: begin
				mem_addr = {STACK_PAGE, sp_q};
				mem_we = 1'b1;
				mem_wdata = {1'b0, fl_q};
				sp_d = sp_q - 8'd1;
				fl_d[FL_I] = 1'b1;
				if (kind_q == KIND_NMI)
					nmi_d = 1'b1;
				ea_d = (kind_q == KIND_NMI) ? VEC_NMI : VEC_IRQ;
				state_d = ST_JSR_HI;
			end
			ST_VEC_LO: begin
				mem_addr = ea_q;
				tmp_d = rd;
				state_d = ST_VEC_HI;
			end
			ST_VEC_HI: begin
				pc_d = {rd, tmp_q};
				fin = 1'b1;
			end
			ST_POP_FL: begin
				fl_d = rd[6:0];
				fl_d[FL_B] = fl_q[FL_B];
				sp_d = sp_q + 8'd1;
				mem_addr = {STACK_PAGE, sp_q + 8'd1};
				state_d = ST_POP_HI;
			end
			ST_POP_HI: begin
				tmp_d = rd;
				sp_d = sp_q + 8'd1;
				mem_addr = {STACK_PAGE, sp_q + 8'd1};
				state_d = ST_POP_LO;
			end
			ST_POP_LO: begin
				pc_d = {tmp_q, rd} + ((op_hi == 4'h6) ? 16'd1 : 16'd0);
				fin = 1'b1;
			end
			default: state_d = ST_IDLE;
		endcase
		if (fin)
			state_d = ST_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0; a_q <= '0; x_q <= '0; y_q <= '0; sp_q <= '0; fl_q <= '0;
			nmi_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pc_q <= pc_d; a_q <= a_d; x_q <= x_d; y_q <= y_d; sp_q <= sp_d; fl_q <= fl_d;
			nmi_q <= nmi_d;
			if (fin)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && in_ready)
			kind_q <= kind;
		if (state_q == ST_OPC)
			op_q <= rd;
		tmp_q <= tmp_d;
		ptmp_q <= ptmp_d;
		ea_q <= ea_d;
		rdata_q <= rdata_d;
		ign_q <= ign_d;
	end

	assign out_valid     = out_valid_q;
	assign pc            = pc_q;
	assign acc           = a_q;
	assign x_index       = x_q;
	assign y_index       = y_q;
	assign stack_pointer = sp_q;
	assign flags         = fl_q;
	assign read_data     = rdata_q;
	assign ignored       = ign_q;

`ifndef ASSERT_OFF
	// no new item while a result is waiting
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> !in_ready)
		else $error("input taken while result pending");
	// result raised only on return to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> state_q == ST_IDLE)
		else $error("result raised mid-item");
	// nmi latch never falls outside reset
	assert property (@(posedge clk) disable iff (!arst_n) $past(nmi_q) |-> nmi_q)
		else $error("nmi latch cleared");
	// memory read state only entered for a read item
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MEMRD) |-> (kind_q == KIND_READ))
		else $error("read state without read item");
`endif

endmodule

>>> bench/partial_8bit_cpu_step_test.sv
// self-checking testbench for the 8-bit cpu step block: directed and random item streams
`timescale 1ns / 1ps
module partial_8bit_cpu_step_test;
	import p8cpu_pkg::*;

	// architectural state after one item, as presented on the result port
	typedef struct {
		logic [15:0] pc;
		logic [7:0]  acc;
		logic [7:0]  x_index;
		logic [7:0]  y_index;
		logic [7:0]  stack_pointer;
		logic [6:0]  flags;
		logic [7:0]  read_data;
		logic        ignored;
	} cpu_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  kind = KIND_WRITE;
	logic [15:0] address = '0;
	logic [7:0]  data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] pc;
	logic [7:0]  acc;
	logic [7:0]  x_index;
	logic [7:0]  y_index;
	logic [7:0]  stack_pointer;
	logic [6:0]  flags;
	logic [7:0]  read_data;
	logic        ignored;

	partial_8bit_cpu_step dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .address(address), .data(data),
		.out_valid(out_valid), .out_ready(out_ready),
		.pc(pc), .acc(acc), .x_index(x_index), .y_index(y_index),
		.stack_pointer(stack_pointer), .flags(flags),
		.read_data(read_data), .ignored(ignored)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------
	// shadow of the core: committed registers, memory and a written map
	// ---------------------------------------------------------------
	logic [7:0]  byte_store [0:65535];
	bit          byte_known [0:65535];
	logic [15:0] cur_pc;
	logic [7:0]  cur_a, cur_x, cur_y, cur_sp;
	logic [6:0]  cur_fl;
	bit          cur_nmi_seen;

	// working copies used while one item is evaluated
	logic [15:0] w_pc;
	logic [7:0]  w_a, w_x, w_y, w_sp;
	logic [6:0]  w_fl;
	bit          w_nmi;
	bit          trial;       // trial evaluation: memory is left untouched
	int          first_gap;   // first unwritten byte a trial run would read, or -1

	cpu_state_t  pending_states [$];
	int          errors = 0;
	int          transfers_in = 0;
	int          results_seen = 0;
	bit          quiet = 1'b0; // no idling on either side while set

	function automatic logic [7:0] mem_rd(logic [15:0] a);
		if (!byte_known[a] && first_gap < 0)
			first_gap = int'(a);
		return byte_known[a] ? byte_store[a] : 8'h00;
	endfunction

	function automatic void mem_wr(logic [15:0] a, logic [7:0] v);
		if (!trial) begin
			byte_store[a] = v;
			byte_known[a] = 1'b1;
		end
	endfunction

	function automatic logic [7:0] fetch_byte();
		logic [7:0] v;
		v = mem_rd(w_pc);
		w_pc = w_pc + 16'd1;
		return v;
	endfunction

	function automatic void push_byte(logic [7:0] v);
		mem_wr({STACK_PAGE, w_sp}, v);
		w_sp = w_sp - 8'd1;
	endfunction

	function automatic logic [7:0] pop_byte();
		w_sp = w_sp + 8'd1;
		return mem_rd({STACK_PAGE, w_sp});
	endfunction

	// low byte goes first, so the high byte comes back first
	function automatic void push_word(logic [15:0] v);
		push_byte(v[7:0]);
		push_byte(v[15:8]);
	endfunction

	function automatic logic [15:0] pop_word();
		logic [7:0] hi;
		hi = pop_byte();
		return {hi, pop_byte()};
	endfunction

	function automatic logic [15:0] read_vector(logic [15:0] a);
		logic [7:0] lo;
		lo = mem_rd(a);
		return {mem_rd(a + 16'd1), lo};
	endfunction

	function automatic void set_nz(logic [7:0] v);
		w_fl[FL_Z] = (v == 8'h00);
		w_fl[FL_N] = v[7];
	endfunction

	// carry here means borrow
	function automatic logic [7:0] subtract(logic [7:0] a, logic [7:0] b, logic borrow);
		logic [8:0] t;
		t = {1'b0, a} - {1'b0, b} - {8'd0, borrow};
		set_nz(t[7:0]);
		w_fl[FL_C] = t[8];
		return t[7:0];
	endfunction

	function automatic void take_interrupt(logic [15:0] vector_at);
		push_word(w_pc);
		push_byte({1'b0, w_fl});
		w_pc = read_vector(vector_at);
		w_fl[FL_I] = 1'b1;
	endfunction

	function automatic void run_opcode();
		logic [7:0]  op, off, zp, ptr, lo8, m, fl_byte;
		logic [15:0] ea;
		logic [8:0]  sum;
		logic        cond, keep_b;
		op = fetch_byte();
		if (op[3:0] == 4'h0) begin
			if (op[4]) begin
				// relative branch: op[7:6] picks N V C Z, op[5] the wanted level
				off = fetch_byte();
				case (op[7:6])
					2'd0: cond = w_fl[FL_N];
					2'd1: cond = w_fl[FL_V];
					2'd2: cond = w_fl[FL_C];
					default: cond = w_fl[FL_Z];
				endcase
				if (cond == op[5])
					w_pc = w_pc + {{8{off[7]}}, off};
			end else begin
				case (op[7:4])
					4'h0: begin
						push_word(w_pc + 16'd1);
						w_fl[FL_B] = 1'b1;
						push_byte({1'b0, w_fl});
						w_pc = read_vector(VEC_IRQ);
						w_fl[FL_I] = 1'b1;
					end
					4'h2: begin
						push_word(w_pc + 16'd1);
						w_pc = read_vector(w_pc);
					end
					4'h4: begin
						keep_b = w_fl[FL_B];
						fl_byte = pop_byte();
						w_fl = fl_byte[6:0];
						w_fl[FL_B] = keep_b;
						w_pc = pop_word();
					end
					4'h6: w_pc = pop_word() + 16'd1;
					4'ha: begin
						w_y = fetch_byte();
						set_nz(w_y);
					end
					4'hc: void'(subtract(w_y, fetch_byte(), 1'b0));
					4'he: void'(subtract(w_x, fetch_byte(), 1'b0));
					default: ;
				endcase
			end
		end else if (op[3:0] == 4'h1) begin
			zp = fetch_byte();
			if (op[4]) begin
				// (zp),Y: Y only touches the low byte
				lo8 = mem_rd({8'h00, zp}) + w_y;
				ea = {mem_rd({8'h00, zp + 8'd1}), lo8};
			end else begin
				ptr = zp + w_x;
				lo8 = mem_rd({8'h00, ptr});
				ea = {mem_rd({8'h00, ptr + 8'd1}), lo8};
			end
			if (op[7:5] == 3'd4)
				mem_wr(ea, w_a);
			else begin
				m = mem_rd(ea);
				case (op[7:5])
					3'd0: begin w_a = w_a | m; set_nz(w_a); end
					3'd1: begin w_a = w_a & m; set_nz(w_a); end
					3'd2: begin w_a = w_a ^ m; set_nz(w_a); end
					3'd3: begin
						sum = {1'b0, w_a} + {1'b0, m} + {8'd0, w_fl[FL_C]};
						w_a = sum[7:0];
						set_nz(w_a);
						w_fl[FL_C] = sum[8];
					end
					3'd5: begin w_a = m; set_nz(w_a); end
					3'd6: void'(subtract(w_a, m, 1'b0));
					default: w_a = subtract(w_a, m, w_fl[FL_C]);
				endcase
			end
		end else if (op[3:0] == 4'h2) begin
			w_x = fetch_byte();
			set_nz(w_x);
		end
	endfunction

	// evaluates one item; a trial run reports the first unwritten byte it would touch
	function automatic bit predict_step(logic [2:0] k, logic [15:0] a, logic [7:0] d,
			bit dry, output cpu_state_t r);
		logic [7:0] rd;
		logic       ign;
		trial = dry;
		first_gap = -1;
		w_pc = cur_pc; w_a = cur_a; w_x = cur_x; w_y = cur_y;
		w_sp = cur_sp; w_fl = cur_fl; w_nmi = cur_nmi_seen;
		rd = 8'h00;
		ign = 1'b0;
		case (k)
			KIND_WRITE: mem_wr(a, d);
			KIND_READ:  rd = mem_rd(a);
			KIND_EXEC:  run_opcode();
			KIND_IRQ: begin
				if (w_fl[FL_I])
					ign = 1'b1;
				else
					take_interrupt(VEC_IRQ);
			end
			KIND_NMI: begin
				if (w_nmi)
					ign = 1'b1;
				else begin
					take_interrupt(VEC_NMI);
					w_nmi = 1'b1;
				end
			end
			default: ;
		endcase
		r = '{w_pc, w_a, w_x, w_y, w_sp, w_fl, rd, ign};
		if (!dry) begin
			cur_pc = w_pc; cur_a = w_a; cur_x = w_x; cur_y = w_y;
			cur_sp = w_sp; cur_fl = w_fl; cur_nmi_seen = w_nmi;
		end
		return first_gap < 0;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ---------------------------------------------------------------
	// driver: one transfer, its expectation queued at acceptance
	// ---------------------------------------------------------------
	task automatic put_item(logic [2:0] k, logic [15:0] a, logic [7:0] d);
		cpu_state_t r;
		int gap;
		in_valid <= 1'b1;
		kind <= k;
		address <= a;
		data <= d;
		do @(posedge clk); while (!in_ready);
		void'(predict_step(k, a, d, 1'b0, r));
		pending_states.push_back(r);
		transfers_in++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// fills in any byte the item would read before it has been written, then sends it
	task automatic send_item(logic [2:0] k, logic [15:0] a, logic [7:0] d);
		cpu_state_t r;
		while (!predict_step(k, a, d, 1'b1, r))
			put_item(KIND_WRITE, first_gap[15:0], 8'($urandom_range(0, 255)));
		put_item(k, a, d);
	endtask

	// places an opcode at the program counter and executes it
	task automatic exec_op(logic [7:0] op);
		put_item(KIND_WRITE, cur_pc, op);
		send_item(KIND_EXEC, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
	endtask

	// ---------------------------------------------------------------
	// result side: random stalls and the checker
	// ---------------------------------------------------------------
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 99) < 30) begin
			stall_left <= pick_gap();
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("mismatch on %s: got %h, expected %h (result %0d)",
			what, got, want, results_seen);
		errors++;
	endtask

	always @(posedge clk) begin
		cpu_state_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_states.size() == 0) begin
				report_mismatch("result count", 16'(results_seen + 1), 16'(transfers_in));
			end else begin
				e = pending_states.pop_front();
				if (pc !== e.pc) report_mismatch("pc", pc, e.pc);
				if (acc !== e.acc) report_mismatch("acc", 16'(acc), 16'(e.acc));
				if (x_index !== e.x_index)
					report_mismatch("x_index", 16'(x_index), 16'(e.x_index));
				if (y_index !== e.y_index)
					report_mismatch("y_index", 16'(y_index), 16'(e.y_index));
				if (stack_pointer !== e.stack_pointer)
					report_mismatch("stack_pointer", 16'(stack_pointer),
						16'(e.stack_pointer));
				if (flags !== e.flags) report_mismatch("flags", 16'(flags), 16'(e.flags));
				if (read_data !== e.read_data)
					report_mismatch("read_data", 16'(read_data), 16'(e.read_data));
				if (ignored !== e.ignored)
					report_mismatch("ignored", 16'(ignored), 16'(e.ignored));
			end
			results_seen++;
		end
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------
	task automatic test_memory_extremes();
		send_item(KIND_WRITE, 16'h0000, 8'h00);
		send_item(KIND_WRITE, 16'hffff, 8'hff);
		send_item(KIND_READ, 16'h0000, 8'h5a);
		send_item(KIND_READ, 16'hffff, 8'h00);
		send_item(KIND_WRITE, 16'haaaa, 8'h55);
		send_item(KIND_READ, 16'haaaa, 8'hff);
	endtask

	// kinds outside the defined range must leave everything alone
	task automatic test_unused_kinds();
		send_item(3'd5, 16'h1234, 8'h12);
		send_item(3'd6, 16'hffff, 8'hff);
		send_item(3'd7, 16'h0000, 8'h00);
	endtask

	// irq taken with I clear, then masked; nmi taken once, then held off by the latch
	task automatic test_interrupts();
		send_item(KIND_IRQ, 16'h0000, 8'h00);
		send_item(KIND_IRQ, 16'h0000, 8'h00);
		send_item(KIND_NMI, 16'h0000, 8'h00);
		send_item(KIND_NMI, 16'h0000, 8'h00);
	endtask

	// one of each instruction family, wrong-slot opcodes included
	task automatic test_instructions();
		logic [7:0] ops [$];
		ops = '{8'hA2, 8'hA0, 8'hE0, 8'hC0, 8'h01, 8'h11, 8'h21, 8'h31, 8'h41,
			8'h51, 8'h61, 8'h71, 8'h81, 8'h91, 8'hA1, 8'hB1, 8'hC1, 8'hD1, 8'hE1,
			8'hF1, 8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0, 8'h20,
			8'h60, 8'h00, 8'h40, 8'h80, 8'h52, 8'hFF, 8'h0F};
		foreach (ops[i])
			exec_op(ops[i]);
	endtask

	function automatic logic [7:0] pick_opcode();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return {4'($urandom_range(0, 15)), 4'h1};      // indirect alu forms
		if (r < 72)
			return {3'($urandom_range(0, 7)), 1'b1, 4'h0}; // branches
		if (r < 80)
			return {4'($urandom_range(0, 15)), 4'h2};      // ldx immediate and its aliases
		if (r < 92) begin
			case ($urandom_range(0, 6))
				0: return 8'h00;
				1: return 8'h20;
				2: return 8'h40;
				3: return 8'h60;
				4: return 8'hA0;
				5: return 8'hC0;
				default: return 8'hE0;
			endcase
		end
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic test_random_stream(int count);
		int r;
		for (int n = 0; n < count; n++) begin
			if (n % 250 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 62) begin
				if ($urandom_range(0, 99) < 75 || !byte_known[cur_pc])
					exec_op(pick_opcode());
				else
					send_item(KIND_EXEC, 16'($urandom_range(0, 65535)),
						8'($urandom_range(0, 255)));
			end else if (r < 74)
				send_item(KIND_WRITE, 16'($urandom_range(0, 65535)),
					8'($urandom_range(0, 255)));
			else if (r < 86)
				send_item(KIND_READ, 16'($urandom_range(0, 65535)),
					8'($urandom_range(0, 255)));
			else if (r < 93)
				send_item(KIND_IRQ, 16'($urandom_range(0, 65535)),
					8'($urandom_range(0, 255)));
			else if (r < 97)
				send_item(KIND_NMI, 16'($urandom_range(0, 65535)),
					8'($urandom_range(0, 255)));
			else
				send_item(3'($urandom_range(5, 7)), 16'($urandom_range(0, 65535)),
					8'($urandom_range(0, 255)));
		end
		quiet = 1'b0;
	endtask

	// run limit, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("timeout with %0d results outstanding", pending_states.size());
		$display("Some tests failed");
		$finish;
	end

	initial begin
		cur_pc = '0; cur_a = '0; cur_x = '0; cur_y = '0;
		cur_sp = '0; cur_fl = '0; cur_nmi_seen = 1'b0;
		foreach (byte_known[i])
			byte_known[i] = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_memory_extremes();
		test_unused_kinds();
		test_interrupts();
		test_instructions();
		test_random_stream(600);

		in_valid <= 1'b0;
		while (pending_states.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("covered %0d input transfers and %0d checked results", transfers_in,
			results_seen);
		$display("memory, execution, interrupt and unused-kind items under random stalls");
		if (errors == 0 && pending_states.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
